// ===== rtl/allocation_bitmap_engine_assert.svh =====
// Assertion macros shared by the bitmap engine RTL.
// Both macros sample on aclk and are disabled while aresetn is low.
`ifndef ALLOCATION_BITMAP_ENGINE_ASSERT_SVH
`define ALLOCATION_BITMAP_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/abe_pkg.sv =====
package abe_pkg;

    localparam int MAP_BITS_DEF  = 32768;
    localparam int WORD_BITS_DEF = 32;

    localparam int IDX_W  = 32;
    localparam int CNT_W  = 16;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;

    // Stream payload layout.
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_BITV_LSB  = STAT_W;
    localparam int OUT_FOUND_LSB = STAT_W + 1;

    localparam logic [IDX_W-1:0] FIRST_RESET = 32'd0;
    localparam logic [IDX_W-1:0] LAST_RESET  = 32'd32767;

    localparam logic [MODE_W-1:0] MODE_SET   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TEST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RUN   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_LAST  = 1'b1;

endpackage

// ===== rtl/allocation_bitmap_engine.sv =====
// Allocation bitmap engine.
// Requests arrive on the s_ stream: s_tuser carries the mode (set bit, clear bit,
// test bit, set run, find first clear) and s_tdata the index, count and search end.
// Every request yields exactly one result on the m_ stream: status, tested bit
// value and the found index. The index window is programmed over the APB port,
// which must only be written while no request is in flight.
// A single-bit request passes through the decode, memory read, modify and write
// back, and output states; the next request is taken only once its result has been
// loaded into the output register. Runs and searches repeat the memory read, then
// modify and write back, for every bitmap word they span; a search stops at the
// first word that holds a clear bit. Each word is updated by a read-modify-write
// loop on the word memory.
// After reset the engine clears the bitmap one word per cycle, all MAP_BITS/WORD_BITS
// words (1024 by default); s_tready stays low until that pass ends, while the
// APB port is served as usual.
// The result sits in an output register; if the receiver stalls, the engine still
// accepts one more request and holds its result until the register drains.
`include "allocation_bitmap_engine_assert.svh"

module allocation_bitmap_engine #(
    parameter int MAP_BITS  = abe_pkg::MAP_BITS_DEF,
    parameter int WORD_BITS = abe_pkg::WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // index [31:0], count [47:32], search_end [79:48]
    input  logic [abe_pkg::IN_DATA_W-1:0] s_tdata,
    // mode [2:0]
    input  logic [abe_pkg::MODE_W-1:0]    s_tuser,
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [1:0], bit_value [2], found_index [34:3], zero pad [39:35]
    output logic [abe_pkg::OUT_DATA_W-1:0] m_tdata
);
    import abe_pkg::*;

    localparam int POS_W  = $clog2(MAP_BITS);
    localparam int WB_LOG = $clog2(WORD_BITS);
    localparam int ADDR_W = POS_W - WB_LOG;
    localparam int DEPTH  = MAP_BITS / WORD_BITS;
    localparam int PAD_W  = OUT_DATA_W - IDX_W - 1 - STAT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_READ,
        S_MOD,
        S_OUT
    } state_t;

    state_t                  state_reg;
    logic [ADDR_W-1:0]       clr_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W:0]          end_reg;
    logic                    cnt_zero_reg;
    logic [POS_W-1:0]        pos_lo_reg;
    logic [POS_W-1:0]        pos_hi_reg;
    logic [ADDR_W-1:0]       wa_reg;
    logic [STAT_W-1:0]       status_reg;
    logic                    bitv_reg;
    logic [POS_W-1:0]        fpos_reg;
    logic                    found_ok_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [IDX_W-1:0]        first_reg;
    logic [IDX_W-1:0]        last_reg;

    logic [WORD_BITS-1:0]    mem [DEPTH];
    logic [WORD_BITS-1:0]    rd_data_reg;

    // ---------------- configuration ----------------
    logic cfg_write;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_LAST) ? last_reg : first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= FIRST_RESET;
            last_reg  <= LAST_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_LAST) begin
                last_reg <= pwdata;
            end else begin
                first_reg <= pwdata;
            end
        end
    end

    // ---------------- decode ----------------
    logic                  win_ok;
    logic                  idx_ge;
    logic                  idx_le;
    logic                  end_ok;
    logic                  req_ok;
    logic [IDX_W-1:0]      lo_diff;
    logic [IDX_W-1:0]      hi_diff;

    always_comb begin
        win_ok  = (first_reg <= last_reg) &&
                  ((last_reg - first_reg) < IDX_W'(MAP_BITS));
        idx_ge  = idx_reg >= first_reg;
        idx_le  = idx_reg <= last_reg;
        end_ok  = !end_reg[IDX_W] && (end_reg[IDX_W-1:0] <= last_reg);
        lo_diff = idx_reg - first_reg;
        hi_diff = end_reg[IDX_W-1:0] - first_reg;
        unique case (mode_reg)
            MODE_SET, MODE_CLEAR, MODE_TEST: req_ok = win_ok && idx_ge && idx_le;
            MODE_RUN:  req_ok = win_ok && idx_ge && idx_le && end_ok;
            MODE_FIND: req_ok = win_ok && idx_ge && end_ok &&
                                (idx_reg <= end_reg[IDX_W-1:0]);
            default:   req_ok = 1'b0;
        endcase
    end

    // ---------------- word modify ----------------
    logic [WB_LOG-1:0]    lo_bit;
    logic [WB_LOG-1:0]    hi_bit;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] probe;
    logic                 zero_hit;
    logic [WB_LOG-1:0]    enc;
    logic                 last_word;

    always_comb begin
        lo_bit = (wa_reg == pos_lo_reg[POS_W-1:WB_LOG]) ? pos_lo_reg[WB_LOG-1:0] : '0;
        hi_bit = (wa_reg == pos_hi_reg[POS_W-1:WB_LOG]) ? pos_hi_reg[WB_LOG-1:0] : '1;
        last_word = wa_reg == pos_hi_reg[POS_W-1:WB_LOG];
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j] = (WB_LOG'(j) >= lo_bit) && (WB_LOG'(j) <= hi_bit);
        end
        // Bits outside the searched span count as set.
        probe    = rd_data_reg | ~mask;
        zero_hit = ~&probe;
        enc      = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!probe[j]) begin
                enc = WB_LOG'(j);
            end
        end
    end

    // ---------------- memory ----------------
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    logic [WORD_BITS-1:0] mem_wd;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = wa_reg;
        mem_wd = rd_data_reg | mask;
        if (state_reg == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = clr_reg;
            mem_wd = '0;
        end else if (state_reg == S_MOD) begin
            mem_we = (mode_reg == MODE_SET) || (mode_reg == MODE_CLEAR) ||
                     (mode_reg == MODE_RUN);
            if (mode_reg == MODE_CLEAR) begin
                mem_wd = rd_data_reg & ~mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[wa_reg];
    end

    // ---------------- sequencer ----------------
    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    logic [IDX_W-1:0] found_val;
    assign found_val = found_ok_reg ? (first_reg + IDX_W'(fpos_reg)) : '0;

    // The output register takes a new result when it is empty or draining.
    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg     <= s_tuser;
                        idx_reg      <= s_tdata[31:0];
                        cnt_zero_reg <= s_tdata[47:32] == '0;
                        bitv_reg     <= 1'b0;
                        found_ok_reg <= 1'b0;
                        unique case (s_tuser)
                            MODE_RUN:  end_reg <= {1'b0, s_tdata[31:0]} +
                                                  (IDX_W + 1)'(s_tdata[47:32]) -
                                                  (IDX_W + 1)'(1);
                            MODE_FIND: end_reg <= {1'b0, s_tdata[79:48]};
                            default:   end_reg <= {1'b0, s_tdata[31:0]};
                        endcase
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    pos_lo_reg <= lo_diff[POS_W-1:0];
                    pos_hi_reg <= hi_diff[POS_W-1:0];
                    wa_reg     <= lo_diff[POS_W-1:WB_LOG];
                    if (mode_reg == MODE_RUN && cnt_zero_reg) begin
                        // An empty run leaves the map untouched; it succeeds if the window is valid.
                        status_reg <= win_ok ? ST_DONE : ST_INVALID;
                        state_reg  <= S_OUT;
                    end else if (req_ok) begin
                        status_reg <= ST_DONE;
                        state_reg  <= S_READ;
                    end else begin
                        status_reg <= ST_INVALID;
                        state_reg  <= S_OUT;
                    end
                end
                S_READ: begin
                    state_reg <= S_MOD;
                end
                S_MOD: begin
                    unique case (mode_reg)
                        MODE_TEST: begin
                            bitv_reg  <= |(rd_data_reg & mask);
                            state_reg <= S_OUT;
                        end
                        MODE_RUN: begin
                            if (last_word) begin
                                state_reg <= S_OUT;
                            end else begin
                                wa_reg    <= wa_reg + ADDR_W'(1);
                                state_reg <= S_READ;
                            end
                        end
                        MODE_FIND: begin
                            if (zero_hit) begin
                                fpos_reg     <= {wa_reg, enc};
                                found_ok_reg <= 1'b1;
                                state_reg    <= S_OUT;
                            end else if (last_word) begin
                                status_reg <= ST_NOT_FOUND;
                                state_reg  <= S_OUT;
                            end else begin
                                wa_reg    <= wa_reg + ADDR_W'(1);
                                state_reg <= S_READ;
                            end
                        end
                        default: begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {PAD_W'(0), found_val, bitv_reg, status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------- assertions ----------------
    `ABE_ASSERT_NEXT(a_accept_decodes, s_tvalid && s_tready, state_reg == S_DECODE,
        "accepted request did not enter decode")
    `ABE_ASSERT_SAME(a_rmw_same_word, state_reg == S_MOD, $stable(wa_reg),
        "word address moved between read and write back")
    `ABE_ASSERT_SAME(a_result_from_out, $rose(m_tvalid_reg), $past(state_reg == S_OUT),
        "result raised outside the output state")
    `ABE_ASSERT_SAME(a_found_zero_on_fail,
        m_tvalid_reg && (m_tdata_reg[STAT_W-1:0] != ST_DONE),
        m_tdata_reg[OUT_FOUND_LSB +: IDX_W] == '0 && !m_tdata_reg[OUT_BITV_LSB],
        "failed request reports nonzero payload")

endmodule
